### rtl/lthd_pkg.sv
// Package: constants, codes and types shared by the pack-format Huffman decoder.
`default_nettype none
package lthd_pkg;
   localparam int MaxLevels = 24;
   localparam int LeafDepth = 256;
   localparam int LvlIdxW   = $clog2(MaxLevels + 1);
   localparam int LeafAddrW = $clog2(LeafDepth);

   localparam logic [7:0] MagicFirst  = 8'o037;
   localparam logic [7:0] MagicSecond = 8'o036;

   localparam logic [1:0] KindByte  = 2'd0;
   localparam logic [1:0] KindDone  = 2'd1;
   localparam logic [1:0] KindError = 2'd2;

   localparam logic [2:0] ErrNone      = 3'd0;
   localparam logic [2:0] ErrBadMagic  = 3'd1;
   localparam logic [2:0] ErrOldFormat = 3'd2;
   localparam logic [2:0] ErrLevels    = 3'd3;
   localparam logic [2:0] ErrLeaves    = 3'd4;
   localparam logic [2:0] ErrSize      = 3'd5;
   localparam logic [2:0] ErrPremature = 3'd6;
   localparam logic [2:0] ErrTooDeep   = 3'd7;

   // file parse phase
   typedef enum logic [7:0] {
      PH_MAGIC  = 8'b0000_0001,
      PH_SIZE   = 8'b0000_0010,
      PH_LEVELS = 8'b0000_0100,
      PH_COUNTS = 8'b0000_1000,
      PH_LEAVES = 8'b0001_0000,
      PH_DECODE = 8'b0010_0000,
      PH_DONE   = 8'b0100_0000,
      PH_ERROR  = 8'b1000_0000
   } phase_type;

   // sequencer
   typedef enum logic [6:0] {
      S_IDLE   = 7'b000_0001,
      S_FWD    = 7'b000_0010,
      S_BWD    = 7'b000_0100,
      S_BIT    = 7'b000_1000,
      S_LEAF   = 7'b001_0000,
      S_FINISH = 7'b010_0000,
      S_FLUSH  = 7'b100_0000
   } seq_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [2:0] err;
   } result_type;
endpackage
`default_nettype wire

### rtl/lthd_leaf_ram.sv
// Generic single-port synchronous RAM with registered read data.
`default_nettype none
module lthd_leaf_ram #(
   parameter int Depth = 256,
   parameter int Width = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wdata,
   output logic      [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

### rtl/level_table_huffman_decoder_core.sv
// Top level: pack-format Huffman decoder, header parse, table build and bit walk.
//
// Usage: the packed file enters one byte per item on the req_ channel
// (req_in_last marks its final byte). Results leave on the rsp_ channel:
// decoded bytes (kind 0), a success status (kind 1) or an error (kind 2),
// with rsp_last_of_run on the final result caused by an input byte.
// Header bytes each pass through accept, close and flush of the item.
// The last leaf byte also runs the level table build: two passes over the
// levels, plus the accept, close and flush of the item.
// A data byte takes up to 8 bit steps through the level table, plus a leaf
// memory read for each leaf hit, plus the accept step and the close and
// flush of the item; decoding may stop inside the byte.
// One item is worked at a time; the next is accepted once the last result
// of the previous one sits in the output register.
// A stalled rsp_ side holds the output register and the engine waits at
// its next result. Reset is synchronous: the block returns to magic check.
// Leaf memory contents are not cleared; decoding only reads written entries.
`default_nettype none
module level_table_huffman_decoder_core
   import lthd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_kind,
   output logic [7:0]      rsp_out_byte,
   output logic [2:0]      rsp_error_code,
   output logic            rsp_last_of_run
);
   seq_type    seq_ff, seq_in;
   phase_type  phase_ff, phase_in;
   logic [8:0]  hidx_ff, hidx_in;
   logic [31:0] exp_size_ff, exp_size_in;
   logic [31:0] emitted_ff, emitted_in;
   logic [LvlIdxW-1:0] deepest_ff, deepest_in;
   logic [8:0]  leaf_total_ff, leaf_total_in;
   logic [24:0] code_ff, code_in;
   logic [LvlIdxW-1:0] level_ff, level_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [2:0]  bitk_ff, bitk_in;
   logic [3:0]  nres_ff, nres_in;
   logic [LvlIdxW-1:0] lcnt_ff, lcnt_in;
   logic [8:0]  acc_ff, acc_in;
   logic        pend_valid_ff, pend_valid_in;
   result_type  pend_ff, pend_in;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff, out_in;
   logic        out_last_ff, out_last_in;

   logic [8:0] leaves_ff [MaxLevels+1];
   logic [8:0] inner_ff  [MaxLevels+1];
   logic [8:0] start_ff  [MaxLevels+1];

   logic               lv_we, in_we, st_we;
   logic [LvlIdxW-1:0] lv_wa, tab_wa;
   logic [8:0]         lv_wd, in_wd, st_wd;

   logic                 ram_we, ram_re;
   logic [LeafAddrW-1:0] ram_addr;
   logic [7:0]           ram_wdata, ram_rdata;

   logic out_free, can_push;

   lthd_leaf_ram #(.Depth(LeafDepth), .Width(8)) u_leaf_ram (
      .clock (clock),
      .wr_en (ram_we),
      .rd_en (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign out_free = !out_valid_ff || !rsp_stall;
   assign can_push = !pend_valid_ff || out_free;

   always_comb begin
      logic        emit;
      logic        replace;
      result_type  res;
      logic [24:0] cv;
      logic [8:0]  inner_v;
      logic [25:0] idx;
      logic [9:0]  eofi;
      logic [9:0]  lt_sum;
      logic [8:0]  lv_val;
      logic        bit_done;
      logic        out_load;
      emit     = 1'b0;
      replace  = 1'b0;
      res      = '0;
      cv       = '0;
      inner_v  = '0;
      idx      = '0;
      eofi     = '0;
      lt_sum   = '0;
      lv_val   = '0;
      bit_done = 1'b0;
      out_load = 1'b0;

      seq_in        = seq_ff;
      phase_in      = phase_ff;
      hidx_in       = hidx_ff;
      exp_size_in   = exp_size_ff;
      emitted_in    = emitted_ff;
      deepest_in    = deepest_ff;
      leaf_total_in = leaf_total_ff;
      code_in       = code_ff;
      level_in      = level_ff;
      byte_in       = byte_ff;
      last_in       = last_ff;
      bitk_in       = bitk_ff;
      nres_in       = nres_ff;
      lcnt_in       = lcnt_ff;
      acc_in        = acc_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      out_valid_in  = out_valid_ff && rsp_stall;

      lv_we = 1'b0; in_we = 1'b0; st_we = 1'b0;
      lv_wa = '0; tab_wa = '0;
      lv_wd = '0; in_wd = '0; st_wd = '0;
      ram_we = 1'b0; ram_re = 1'b0; ram_addr = '0; ram_wdata = req_in_byte;
      req_stall = (seq_ff != S_IDLE);

      case (seq_ff)
         S_IDLE: begin
            if (req_valid) begin
               byte_in = req_in_byte;
               last_in = req_in_last;
               nres_in = '0;
               seq_in  = S_FINISH;
               case (phase_ff)
                  PH_MAGIC: begin
                     if (hidx_ff == 9'd0) begin
                        if (req_in_byte == MagicFirst) begin
                           hidx_in = 9'd1;
                        end else begin
                           emit = 1'b1; res = '{KindError, 8'd0, ErrBadMagic};
                        end
                     end else if (req_in_byte == MagicSecond) begin
                        phase_in    = PH_SIZE;
                        hidx_in     = '0;
                        exp_size_in = '0;
                     end else if (req_in_byte == MagicFirst) begin
                        emit = 1'b1; res = '{KindError, 8'd0, ErrOldFormat};
                     end else begin
                        emit = 1'b1; res = '{KindError, 8'd0, ErrBadMagic};
                     end
                  end
                  PH_SIZE: begin
                     exp_size_in = {exp_size_ff[23:0], req_in_byte};
                     hidx_in     = hidx_ff + 9'd1;
                     if (hidx_ff >= 9'd3) begin
                        phase_in = PH_LEVELS;
                     end
                  end
                  PH_LEVELS: begin
                     if (req_in_byte > 8'(MaxLevels)) begin
                        emit = 1'b1; res = '{KindError, 8'd0, ErrLevels};
                     end else begin
                        deepest_in    = LvlIdxW'(req_in_byte);
                        leaf_total_in = '0;
                        if (req_in_byte == 8'd0) begin
                           phase_in = PH_LEAVES;
                           hidx_in  = '0;
                        end else begin
                           phase_in = PH_COUNTS;
                           hidx_in  = 9'd1;
                        end
                     end
                  end
                  PH_COUNTS: begin
                     if (hidx_ff >= 9'd1 && hidx_ff <= 9'(MaxLevels)) begin
                        lv_we = 1'b1;
                        lv_wa = hidx_ff[LvlIdxW-1:0];
                        lv_wd = {1'b0, req_in_byte};
                     end
                     lt_sum = {1'b0, leaf_total_ff} + {2'b00, req_in_byte};
                     leaf_total_in = (lt_sum > 10'(LeafDepth)) ? 9'(LeafDepth)
                                                               : lt_sum[8:0];
                     if (hidx_ff >= {4'd0, deepest_ff}) begin
                        phase_in = PH_LEAVES;
                        hidx_in  = '0;
                     end else begin
                        hidx_in = hidx_ff + 9'd1;
                     end
                  end
                  PH_LEAVES: begin
                     if (hidx_ff < leaf_total_ff) begin
                        if (hidx_ff >= 9'(LeafDepth - 1)) begin
                           emit = 1'b1; res = '{KindError, 8'd0, ErrLeaves};
                        end else begin
                           ram_we   = 1'b1;
                           ram_addr = hidx_ff[LeafAddrW-1:0];
                           hidx_in  = hidx_ff + 9'd1;
                        end
                     end else begin
                        // extra leaf byte, then the table build
                        if (hidx_ff < 9'(LeafDepth)) begin
                           ram_we   = 1'b1;
                           ram_addr = hidx_ff[LeafAddrW-1:0];
                        end
                        phase_in = PH_DECODE;
                        hidx_in  = '0;
                        code_in  = '0;
                        level_in = LvlIdxW'(1);
                        lcnt_in  = LvlIdxW'(1);
                        acc_in   = '0;
                        seq_in   = S_FWD;
                     end
                  end
                  PH_DECODE: begin
                     bitk_in = 3'd7;
                     seq_in  = S_BIT;
                  end
                  PH_DONE: begin
                     emit = 1'b1; res = '{KindDone, 8'd0, ErrNone};
                  end
                  default: begin
                     emit = 1'b1; res = '{KindError, 8'd0, hidx_ff[2:0]};
                  end
               endcase
            end
         end
         S_FWD: begin
            if (lcnt_ff > deepest_ff || lcnt_ff == '0) begin
               lcnt_in = deepest_ff;
               acc_in  = '0;
               seq_in  = (deepest_ff == '0) ? S_FINISH : S_BWD;
            end else begin
               st_we   = 1'b1;
               tab_wa  = lcnt_ff;
               st_wd   = acc_ff;
               acc_in  = acc_ff + leaves_ff[lcnt_ff];
               lcnt_in = lcnt_ff + LvlIdxW'(1);
            end
         end
         S_BWD: begin
            // acc holds the running node count of the levels below
            lv_val = leaves_ff[lcnt_ff];
            if (lcnt_ff == deepest_ff) begin
               lv_val = lv_val + 9'd2;
            end
            in_we   = 1'b1;
            tab_wa  = lcnt_ff;
            in_wd   = {1'b0, acc_ff[8:1]};
            acc_in  = {1'b0, acc_ff[8:1]} + lv_val;
            lcnt_in = lcnt_ff - LvlIdxW'(1);
            if (lcnt_ff == LvlIdxW'(1)) begin
               seq_in = S_FINISH;
            end
         end
         S_BIT: begin
            if (can_push) begin
               if (phase_ff != PH_DECODE) begin
                  seq_in = S_FINISH;
               end else if (level_ff == '0 || level_ff > deepest_ff) begin
                  emit = 1'b1; res = '{KindError, 8'd0, ErrTooDeep};
                  seq_in = S_FINISH;
               end else begin
                  cv      = {code_ff[23:0], byte_ff[bitk_ff]};
                  code_in = cv;
                  inner_v = inner_ff[level_ff];
                  if (cv >= {16'd0, inner_v}) begin
                     idx  = {1'b0, cv - {16'd0, inner_v}} + {17'd0, start_ff[level_ff]};
                     eofi = {1'b0, leaf_total_ff} + 10'd1;
                     if (idx == {16'd0, eofi}) begin
                        if (emitted_ff == exp_size_ff) begin
                           phase_in = PH_DONE;
                           emit = 1'b1; res = '{KindDone, 8'd0, ErrNone};
                        end else begin
                           emit = 1'b1; res = '{KindError, 8'd0, ErrSize};
                        end
                        seq_in = S_FINISH;
                     end else if (idx > {16'd0, eofi} || idx >= 26'(LeafDepth)) begin
                        emit = 1'b1; res = '{KindError, 8'd0, ErrTooDeep};
                        seq_in = S_FINISH;
                     end else begin
                        ram_re   = 1'b1;
                        ram_addr = idx[LeafAddrW-1:0];
                        code_in  = '0;
                        level_in = LvlIdxW'(1);
                        seq_in   = S_LEAF;
                     end
                  end else if (level_ff >= deepest_ff) begin
                     emit = 1'b1; res = '{KindError, 8'd0, ErrTooDeep};
                     seq_in = S_FINISH;
                  end else begin
                     level_in = level_ff + LvlIdxW'(1);
                     bit_done = 1'b1;
                  end
               end
            end
         end
         S_LEAF: begin
            if (can_push) begin
               emit       = 1'b1;
               res        = '{KindByte, ram_rdata, ErrNone};
               emitted_in = emitted_ff + 32'd1;
               bit_done   = 1'b1;
            end
         end
         S_FINISH: begin
            if (can_push) begin
               seq_in = S_FLUSH;
               if (last_ff && phase_ff != PH_DONE && phase_ff != PH_ERROR) begin
                  res = '{KindError, 8'd0, ErrPremature};
                  if (nres_ff == 4'd8) begin
                     replace = 1'b1;
                  end else begin
                     emit = 1'b1;
                  end
               end
            end
         end
         S_FLUSH: begin
            if (!pend_valid_ff) begin
               seq_in = S_IDLE;
            end else if (out_free) begin
               out_load      = 1'b1;
               out_in        = pend_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               seq_in        = S_IDLE;
            end
         end
         default: begin
            seq_in = S_IDLE;
         end
      endcase

      if (bit_done) begin
         if (bitk_ff == 3'd0) begin
            seq_in = S_FINISH;
         end else begin
            bitk_in = bitk_ff - 3'd1;
            seq_in  = S_BIT;
         end
      end

      if ((emit || replace) && res.kind == KindError) begin
         phase_in = PH_ERROR;
         hidx_in  = {6'd0, res.err};
      end

      if (emit) begin
         if (pend_valid_ff) begin
            out_load    = 1'b1;
            out_in      = pend_ff;
            out_last_in = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_in       = res;
         nres_in       = nres_ff + 4'd1;
      end else if (replace) begin
         pend_in = res;
      end

      if (out_load) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff        <= S_IDLE;
         phase_ff      <= PH_MAGIC;
         hidx_ff       <= '0;
         exp_size_ff   <= '0;
         emitted_ff    <= '0;
         deepest_ff    <= '0;
         leaf_total_ff <= '0;
         code_ff       <= '0;
         level_ff      <= LvlIdxW'(1);
         nres_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         seq_ff        <= seq_in;
         phase_ff      <= phase_in;
         hidx_ff       <= hidx_in;
         exp_size_ff   <= exp_size_in;
         emitted_ff    <= emitted_in;
         deepest_ff    <= deepest_in;
         leaf_total_ff <= leaf_total_in;
         code_ff       <= code_in;
         level_ff      <= level_in;
         nres_ff       <= nres_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      last_ff     <= last_in;
      bitk_ff     <= bitk_in;
      lcnt_ff     <= lcnt_in;
      acc_ff      <= acc_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
      if (lv_we) begin
         leaves_ff[lv_wa] <= lv_wd;
      end
      if (in_we) begin
         inner_ff[tab_wa] <= in_wd;
      end
      if (st_we) begin
         start_ff[tab_wa] <= st_wd;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_kind        = out_ff.kind;
   assign rsp_out_byte    = out_ff.data;
   assign rsp_error_code  = out_ff.err;
   assign rsp_last_of_run = out_last_ff;
endmodule
`default_nettype wire
